FILE: sv/wlsv_pkg.sv
// shared types and constants of the window least-squares velocity block
`timescale 1ns / 1ps
`default_nettype none

package wlsv_pkg;

    // default geometry
    localparam int STRIPS_DEF = 16;
    localparam int WINDOW_DEF = 8;

    // register reset values
    localparam logic [15:0] FRAME_PERIOD_RESET = 16'd25000;
    localparam logic [14:0] V_MAX_RESET        = 15'd3000;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_PERIOD = 2'd0;
    localparam logic [1:0] CFG_V_MAX        = 2'd1;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    // how the result of an item is formed
    typedef enum logic [1:0] {
        RES_FAIL,
        RES_OVER,
        RES_FIT
    } res_code_t;

    // commands from controller to datapath
    typedef struct packed {
        logic      clear_wr;
        logic      start;
        logic      rd_en;
        logic      load_new;
        logic      calc1;
        logic      calc2;
        logic      calc3;
        logic      judge;
        logic      div_mul;
        logic      div_sub;
        logic [1:0] div_shift;
        logic      out_load;
        res_code_t code;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic in_range;
        logic fail;
        logic big;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/window_least_squares_velocity.sv
// Per-strip sliding-window least-squares velocity estimator, top level.
// Input stream: s_tuser carries the strip number, s_tdata the position (mm,
// 0 = no object) and the scan time offset (us). Each transfer for a strip
// below STRIPS shifts its window of WINDOW samples; each yields exactly one
// result transfer: m_tuser holds strip and status, m_tdata the signed velocity
// in mm/s (approach positive, 0 unless status is 0).
// Configuration: cfg_index 0 is the frame period, 1 the speed limit; writes
// are always accepted and must be done while the block is idle.
// Timing: one item at a time. The result follows the window shift, the sum
// pipeline drain, the product steps, the judgement and, when the fit is not
// rejected early, the decimal divider (six digits, each a multiply by ten
// and compare-subtract steps); s_tready returns with the result. The shift
// reads one window entry per cycle.
// Reset: the window memory is swept to zero one entry per cycle, with
// s_tready low; registers return to their reset values.
// Stall: the result waits in the output register; the next item is accepted
// and processed meanwhile, and its result is held with s_tready low until
// the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module window_least_squares_velocity #(
    parameter int STRIPS = wlsv_pkg::STRIPS_DEF,
    parameter int WINDOW = wlsv_pkg::WINDOW_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // position_mm [15:0], time_offset_us [31:16]
    input  wire  [3:0]  s_tuser,   // strip [3:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // velocity_mm_s [15:0]
    output logic [5:0]  m_tuser    // strip_out [3:0], status [5:4]
);
    import wlsv_pkg::*;

    cmd_t                      cmd;
    dp_status_t                st;
    logic [$clog2(WINDOW)-1:0] k_idx;

    // sequencing
    wlsv_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd),
        .k_idx    (k_idx)
    );

    // storage and arithmetic
    wlsv_dp #(
        .STRIPS (STRIPS),
        .WINDOW (WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .k_idx     (k_idx),
        .st        (st),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: sv/wlsv_dp.sv
// datapath: window memory, sum pipeline, products, decimal divider, output register
`timescale 1ns / 1ps
`default_nettype none

module wlsv_dp #(
    parameter int STRIPS = 16,
    parameter int WINDOW = 8
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wlsv_pkg::cmd_t                cmd,
    input  wire  [$clog2(WINDOW)-1:0]     k_idx,
    output wlsv_pkg::dp_status_t          st,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [1:0]                    cfg_index,
    input  wire  [15:0]                   cfg_data,
    input  wire  [3:0]                    s_tuser,
    input  wire  [31:0]                   s_tdata,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [15:0]                   m_tdata,
    output logic [5:0]                    m_tuser
);
    import wlsv_pkg::*;

    localparam int AW   = $clog2(STRIPS * WINDOW);
    localparam int JW   = $clog2(WINDOW);
    localparam int XW   = 16 + JW;
    localparam int NW   = $clog2(WINDOW + 1);
    localparam int SXW  = XW + JW;
    localparam int SYW  = 16 + JW;
    localparam int SXXW = 2 * XW + JW;
    localparam int SXYW = XW + 16 + JW;
    localparam int PW   = 2 * XW + 2 * JW + 2;
    localparam int RW   = PW + 3;
    localparam int DEPTH = STRIPS * WINDOW;

    // configuration registers
    logic [15:0] fp_reg;
    logic [14:0] vmax_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg   <= FRAME_PERIOD_RESET;
            vmax_reg <= V_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_PERIOD: fp_reg   <= cfg_data;
                CFG_V_MAX:        vmax_reg <= cfg_data[14:0];
                default:          ;
            endcase
        end
    end

    // latched input item
    logic [3:0]  strip_reg;
    logic [15:0] pos_in_reg;
    logic [15:0] off_in_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            strip_reg  <= s_tuser;
            pos_in_reg <= s_tdata[15:0];
            off_in_reg <= s_tdata[31:16];
        end
    end

    logic [AW-1:0] base;
    assign base        = AW'(32'(strip_reg) * WINDOW);
    assign st.in_range = (32'(strip_reg) < STRIPS);

    // window memory, one entry {offset, position}
    logic [31:0]   win_mem [DEPTH];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          pend_v_reg;
    logic          pend_in_reg;
    logic [AW-1:0] pend_addr_reg;
    logic [JW-1:0] pend_j_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [31:0]   pend_data;

    assign rd_addr   = base + AW'(k_idx) + AW'(1);
    assign pend_data = pend_in_reg ? {off_in_reg, pos_in_reg} : rd_data_reg;
    assign wr_en     = cmd.clear_wr | pend_v_reg;
    assign wr_addr   = cmd.clear_wr ? clr_addr_reg : pend_addr_reg;
    assign wr_data   = cmd.clear_wr ? 32'd0 : pend_data;
    assign st.clear_last = (clr_addr_reg == AW'(DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            win_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= win_mem[rd_addr];
        end
    end

    // pending write-back and clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg   <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            pend_v_reg <= cmd.rd_en | cmd.load_new;
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_in_reg   <= cmd.load_new;
        pend_addr_reg <= cmd.load_new ? base + AW'(WINDOW - 1) : base + AW'(k_idx);
        pend_j_reg    <= cmd.load_new ? JW'(WINDOW - 1) : k_idx;
    end

    // stage a: sample time
    logic [XW-1:0] xj;
    logic          a_v_reg;
    logic [XW-1:0] a_x_reg;
    logic [15:0]   a_y_reg;
    logic          prev_nz_reg;
    logic          newest_nz_reg;

    assign xj = XW'(fp_reg) * XW'(pend_j_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= pend_v_reg && (pend_data[15:0] != 16'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        a_x_reg <= xj + XW'(pend_data[31:16]);
        a_y_reg <= pend_data[15:0];
        if (pend_v_reg && pend_j_reg == JW'(WINDOW - 1))
        begin
            newest_nz_reg <= (pend_data[15:0] != 16'd0);
        end
        if (pend_v_reg && pend_j_reg == JW'(WINDOW - 2))
        begin
            prev_nz_reg <= (pend_data[15:0] != 16'd0);
        end
    end

    // stage b: squares and cross products
    logic               b_v_reg;
    logic [XW-1:0]      b_x_reg;
    logic [15:0]        b_y_reg;
    logic [2*XW-1:0]    b_xx_reg;
    logic [XW+15:0]     b_xy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_x_reg  <= a_x_reg;
        b_y_reg  <= a_y_reg;
        b_xx_reg <= a_x_reg * a_x_reg;
        b_xy_reg <= a_x_reg * a_y_reg;
    end

    // stage c: running sums
    logic [NW-1:0]   n_reg;
    logic [SXW-1:0]  sx_reg;
    logic [SYW-1:0]  sy_reg;
    logic [SXXW-1:0] sxx_reg;
    logic [SXYW-1:0] sxy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            n_reg   <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            sxy_reg <= '0;
        end
        else if (b_v_reg)
        begin
            n_reg   <= n_reg + NW'(1);
            sx_reg  <= sx_reg + SXW'(b_x_reg);
            sy_reg  <= sy_reg + SYW'(b_y_reg);
            sxx_reg <= sxx_reg + SXXW'(b_xx_reg);
            sxy_reg <= sxy_reg + SXYW'(b_xy_reg);
        end
    end

    // numerator and divisor products
    logic [NW+SXYW-1:0] p1;
    logic [SXW+SYW-1:0] p2;
    logic [NW+SXXW-1:0] p3;
    logic [2*SXW-1:0]   p4;
    logic [PW-1:0]      m1_reg;
    logic [PW-1:0]      m2_reg;
    logic [PW-1:0]      m3_reg;
    logic [PW-1:0]      m4_reg;
    logic [PW-1:0]      num_reg;
    logic [PW-1:0]      den_reg;
    logic [PW-1:0]      anum_reg;
    logic               neg_reg;

    assign p1 = n_reg * sxy_reg;
    assign p2 = sx_reg * sy_reg;
    assign p3 = n_reg * sxx_reg;
    assign p4 = sx_reg * sx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.calc1)
        begin
            m1_reg <= PW'(p1);
            m2_reg <= PW'(p2);
        end
        if (cmd.calc2)
        begin
            m3_reg  <= PW'(p3);
            m4_reg  <= PW'(p4);
            num_reg <= m1_reg - m2_reg;
        end
        if (cmd.calc3)
        begin
            den_reg  <= m3_reg - m4_reg;
            anum_reg <= num_reg[PW-1] ? (~num_reg + PW'(1)) : num_reg;
            neg_reg  <= num_reg[PW-1];
        end
    end

    // early decisions
    assign st.fail = (n_reg < NW'(2)) || (!prev_nz_reg && !newest_nz_reg)
                     || den_reg[PW-1] || (den_reg == '0);
    assign st.big  = (anum_reg >= den_reg);

    // decimal long division, one binary digit step per cycle
    logic [RW-1:0] r_reg;
    logic [19:0]   q_reg;
    logic [3:0]    dig_reg;
    logic [RW-1:0] dsh;
    logic          ge;
    logic [3:0]    dig_new;

    assign dsh     = RW'(den_reg) << cmd.div_shift;
    assign ge      = (r_reg >= dsh);
    assign dig_new = dig_reg | (ge ? (4'd1 << cmd.div_shift) : 4'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.judge)
        begin
            r_reg <= RW'(anum_reg);
            q_reg <= '0;
        end
        else if (cmd.div_mul)
        begin
            r_reg   <= (r_reg << 3) + (r_reg << 1);
            dig_reg <= '0;
        end
        else if (cmd.div_sub)
        begin
            if (ge)
            begin
                r_reg <= r_reg - dsh;
            end
            dig_reg <= dig_new;
            if (cmd.div_shift == 2'd0)
            begin
                q_reg <= q_reg * 20'd10 + 20'(dig_new);
            end
        end
    end

    // output register
    logic        over;
    logic        out_v_reg;
    logic [15:0] vel_reg;
    logic [1:0]  stat_reg;
    logic [3:0]  strip_out_reg;

    assign over = (q_reg > 20'(vmax_reg)) || ((q_reg == 20'(vmax_reg)) && (r_reg != '0));
    assign st.out_free = !out_v_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_v_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            strip_out_reg <= strip_reg;
            unique case (cmd.code)
                RES_FIT:
                begin
                    if (over)
                    begin
                        vel_reg  <= 16'd0;
                        stat_reg <= ST_OVER;
                    end
                    else
                    begin
                        vel_reg  <= neg_reg ? q_reg[15:0] : (16'd0 - q_reg[15:0]);
                        stat_reg <= ST_OK;
                    end
                end
                RES_OVER:
                begin
                    vel_reg  <= 16'd0;
                    stat_reg <= ST_OVER;
                end
                default:
                begin
                    vel_reg  <= 16'd0;
                    stat_reg <= ST_FEW;
                end
            endcase
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = vel_reg;
    assign m_tuser  = {stat_reg, strip_out_reg};

endmodule

`default_nettype wire

FILE: sv/wlsv_ctrl.sv
// controller: sequences clear sweep, window shift, sums, products and division
`timescale 1ns / 1ps
`default_nettype none

module wlsv_ctrl #(
    parameter int WINDOW = 8
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wlsv_pkg::dp_status_t        st,
    output wlsv_pkg::cmd_t              cmd,
    output logic [$clog2(WINDOW)-1:0]   k_idx
);
    import wlsv_pkg::*;

    localparam int JW = $clog2(WINDOW);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_LOAD,
        S_DRAIN,
        S_CALC1,
        S_CALC2,
        S_CALC3,
        S_JUDGE,
        S_DIV,
        S_FIN
    } state_t;

    state_t    state_reg, state_next;
    logic [JW-1:0] k_reg, k_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic [2:0]    sub_reg, sub_next;
    res_code_t     code_reg, code_next;

    assign s_tready = (state_reg == S_IDLE);
    assign k_idx    = k_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        sub_next   = sub_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                k_next = '0;
                if (st.in_range)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    code_next  = RES_FAIL;
                    state_next = S_FIN;
                end
            end
            S_SHIFT:
            begin
                cmd.rd_en = 1'b1;
                if (k_reg == JW'(WINDOW - 2))
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    k_next = k_reg + JW'(1);
                end
            end
            S_LOAD:
            begin
                cmd.load_new = 1'b1;
                cnt_next     = '0;
                state_next   = S_DRAIN;
            end
            S_DRAIN:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    state_next = S_CALC1;
                end
            end
            S_CALC1:
            begin
                cmd.calc1  = 1'b1;
                state_next = S_CALC2;
            end
            S_CALC2:
            begin
                cmd.calc2  = 1'b1;
                state_next = S_CALC3;
            end
            S_CALC3:
            begin
                cmd.calc3  = 1'b1;
                state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                cmd.judge = 1'b1;
                cnt_next  = '0;
                sub_next  = '0;
                if (st.fail)
                begin
                    code_next  = RES_FAIL;
                    state_next = S_FIN;
                end
                else if (st.big)
                begin
                    code_next  = RES_OVER;
                    state_next = S_FIN;
                end
                else
                begin
                    code_next  = RES_FIT;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sub_reg == 3'd0)
                begin
                    cmd.div_mul = 1'b1;
                    sub_next    = 3'd1;
                end
                else
                begin
                    cmd.div_sub   = 1'b1;
                    cmd.div_shift = 2'(3'd4 - sub_reg);
                    if (sub_reg == 3'd4)
                    begin
                        sub_next = 3'd0;
                        cnt_next = cnt_reg + 3'd1;
                        if (cnt_reg == 3'd5)
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else
                    begin
                        sub_next = sub_reg + 3'd1;
                    end
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            k_reg     <= '0;
            cnt_reg   <= '0;
            sub_reg   <= '0;
            code_reg  <= RES_FAIL;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            sub_reg   <= sub_next;
            code_reg  <= code_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/wlsv_checker.sv
// port-level checks of the velocity estimator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module wlsv_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata,
    input wire [5:0]  m_tuser
);
    import wlsv_pkg::*;

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // only the three defined status codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[5:4] == ST_OK || m_tuser[5:4] == ST_FEW
                      || m_tuser[5:4] == ST_OVER))
        else $error("undefined status");

    // rejected estimates carry zero velocity
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[5:4] != ST_OK |-> m_tdata == 16'd0)
        else $error("nonzero velocity with failure status");

    // accepted estimates stay within the 15-bit limit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[5:4] == ST_OK |-> m_tdata != 16'h8000)
        else $error("velocity out of range");

endmodule

bind window_least_squares_velocity wlsv_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
